FILE: src/limit_order_book_matcher_assert.svh
// Assertion macros used by the order book matcher top level
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
// Implication checked at every clock edge outside reset
`define LOBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/lobm_pkg.sv
// Package with shared types and constants of the order book matcher
package lobm_pkg;
    localparam logic [29:0] BacklogMod = 30'd1000000007;
    localparam int VALUE_BITS = 30;

    // Command broadcast along the book chain
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_DEC,     // reduce the head entry by the given amount
        CMD_POP,     // remove the head entry, shift the row forward
        CMD_INSERT   // insert a new entry in sorted position
    } t_cmd;

    // a + b mod BacklogMod, both inputs already below BacklogMod
    function automatic logic [29:0] mod_add(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, BacklogMod}) s = s - {1'b0, BacklogMod};
        return s[29:0];
    endfunction

    function automatic logic [29:0] mod_sub(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (a < b) s = s + {1'b0, BacklogMod};
        return s[29:0];
    endfunction

    // reduce a value below 2^30 (< 2*BacklogMod) by one conditional subtract
    function automatic logic [29:0] mod_red(input logic [29:0] a);
        return (a >= BacklogMod) ? a - BacklogMod : a;
    endfunction
endpackage

FILE: src/lobm_cell.sv
// One slot of a sorted book row: holds an entry, shifts with its neighbours
module lobm_cell
    import lobm_pkg::*;
#(
    parameter int VALUE_BITS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_want_max,
    input  t_cmd                  i_cmd,
    input  logic [VALUE_BITS-1:0] i_cmd_price,
    input  logic [VALUE_BITS-1:0] i_cmd_amount,
    input  logic                  i_is_head,
    // previous neighbour (towards head)
    input  logic                  i_prev_valid,
    input  logic                  i_prev_goes_after,
    input  logic [VALUE_BITS-1:0] i_prev_price,
    input  logic [VALUE_BITS-1:0] i_prev_amount,
    // next neighbour (towards tail)
    input  logic                  i_next_valid,
    input  logic [VALUE_BITS-1:0] i_next_price,
    input  logic [VALUE_BITS-1:0] i_next_amount,
    output logic                  o_valid,
    output logic                  o_goes_after,
    output logic [VALUE_BITS-1:0] o_price,
    output logic [VALUE_BITS-1:0] o_amount
);
    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_price;
    logic [VALUE_BITS-1:0] r_amount;

    // new entry ranks behind this one (ties keep arrival order)
    assign o_goes_after = r_valid &&
        (i_want_max ? (r_price >= i_cmd_price) : (r_price <= i_cmd_price));
    assign o_valid  = r_valid;
    assign o_price  = r_price;
    assign o_amount = r_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_cmd)
                CMD_DEC: begin
                    if (i_is_head) r_amount <= r_amount - i_cmd_amount;
                end
                CMD_POP: begin
                    r_valid  <= i_next_valid;
                    r_price  <= i_next_price;
                    r_amount <= i_next_amount;
                end
                CMD_INSERT: begin
                    if (!o_goes_after) begin
                        if (i_prev_goes_after || i_is_head) begin
                            r_valid  <= 1'b1;
                            r_price  <= i_cmd_price;
                            r_amount <= i_cmd_amount;
                        end else begin
                            r_valid  <= i_prev_valid;
                            r_price  <= i_prev_price;
                            r_amount <= i_prev_amount;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: src/lobm_book.sv
// One book: a chain of sorted cells with its best entry at the head
module lobm_book
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = 256,
    parameter int VALUE_BITS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_want_max,
    input  t_cmd                  i_cmd,
    input  logic [VALUE_BITS-1:0] i_cmd_price,
    input  logic [VALUE_BITS-1:0] i_cmd_amount,
    output logic                  o_head_valid,
    output logic [VALUE_BITS-1:0] o_head_price,
    output logic [VALUE_BITS-1:0] o_head_amount,
    output logic                  o_full
);
    logic [BOOK_DEPTH-1:0]                 w_valid, w_after;
    logic [BOOK_DEPTH-1:0][VALUE_BITS-1:0] w_price, w_amount;

    for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
        lobm_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_want_max       (i_want_max),
            .i_cmd            (i_cmd),
            .i_cmd_price      (i_cmd_price),
            .i_cmd_amount     (i_cmd_amount),
            .i_is_head        (g == 0),
            .i_prev_valid     ((g == 0) ? 1'b0 : w_valid[(g == 0) ? 0 : g-1]),
            .i_prev_goes_after((g == 0) ? 1'b0 : w_after[(g == 0) ? 0 : g-1]),
            .i_prev_price     (w_price[(g == 0) ? 0 : g-1]),
            .i_prev_amount    (w_amount[(g == 0) ? 0 : g-1]),
            .i_next_valid     ((g == BOOK_DEPTH-1) ? 1'b0
                               : w_valid[(g == BOOK_DEPTH-1) ? g : g+1]),
            .i_next_price     (w_price[(g == BOOK_DEPTH-1) ? g : g+1]),
            .i_next_amount    (w_amount[(g == BOOK_DEPTH-1) ? g : g+1]),
            .o_valid          (w_valid[g]),
            .o_goes_after     (w_after[g]),
            .o_price          (w_price[g]),
            .o_amount         (w_amount[g])
        );
    end

    assign o_head_valid  = w_valid[0];
    assign o_head_price  = w_price[0];
    assign o_head_amount = w_amount[0];
    assign o_full        = w_valid[BOOK_DEPTH-1];
endmodule

FILE: src/limit_order_book_matcher.sv
// Top level of the limit order book matcher with price priority
//
//  channel | dir | handshake                | payload
//  s_axis  | in  | s_axis_tvalid/tready     | tdata: price, amount ; tuser: side
//  m_axis  | out | m_axis_tvalid/tready     | tdata: backlog_mod ; tuser: book_full
//
// An order is taken in the idle state, then matched level by level against
// the opposite book (its head reduced or popped) until it no longer crosses,
// then inserted into its own chain, and its result is held in the output state.
// Pop and insert shift the cells of a sorted chain at once; a decrement changes only the head.
// Reset (synchronous, active low) empties both books and clears the total.
// A result waits in the output register; the next order is taken once it leaves.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [29:0] order_price, [59:30] order_amount
    input  logic        s_axis_tuser,   // [0] order_side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [29:0] backlog_mod
    output logic        m_axis_tuser    // [0] book_full
);
`include "limit_order_book_matcher_assert.svh"

    typedef enum logic [1:0] { ST_IDLE, ST_MATCH, ST_PLACE, ST_OUT } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_price, r_rem;
    logic                  r_sell;
    logic [29:0]           r_total;
    logic                  r_full;

    t_cmd bid_cmd, ask_cmd;
    logic [VALUE_BITS-1:0] bid_amt, ask_amt, opp_amt, opp_price, own_cmd_amt;
    logic bid_hv, ask_hv, bid_full, ask_full, opp_hv, crosses, own_full;
    logic [VALUE_BITS-1:0] bid_hp, ask_hp, bid_ha, ask_ha;
    logic [29:0] sub_amt, add_amt;

    assign opp_hv    = r_sell ? bid_hv : ask_hv;
    assign opp_price = r_sell ? bid_hp : ask_hp;
    assign opp_amt   = r_sell ? bid_ha : ask_ha;
    assign own_full  = r_sell ? ask_full : bid_full;
    assign crosses   = r_sell ? (opp_price >= r_price) : (opp_price <= r_price);

    // amounts below 2^30 reduce with one subtract
    assign sub_amt = mod_red(30'((opp_amt <= r_rem) ? opp_amt : r_rem));
    assign add_amt = mod_red(30'(r_rem));

    // command decode: matching acts on the opposite chain, placing on the own
    always_comb begin
        bid_cmd = CMD_NONE;
        ask_cmd = CMD_NONE;
        own_cmd_amt = r_rem;
        if (r_state == ST_MATCH && r_rem != '0 && opp_hv && crosses) begin
            if (r_sell) bid_cmd = (bid_ha <= r_rem) ? CMD_POP : CMD_DEC;
            else        ask_cmd = (ask_ha <= r_rem) ? CMD_POP : CMD_DEC;
        end else if (r_state == ST_PLACE && r_rem != '0 && !own_full) begin
            if (r_sell) ask_cmd = CMD_INSERT;
            else        bid_cmd = CMD_INSERT;
        end
    end
    assign bid_amt = r_sell ? r_rem : own_cmd_amt;
    assign ask_amt = r_sell ? own_cmd_amt : r_rem;

    lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .VALUE_BITS(VALUE_BITS)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_want_max(1'b1), .i_cmd(bid_cmd),
        .i_cmd_price(r_price), .i_cmd_amount(bid_amt),
        .o_head_valid(bid_hv), .o_head_price(bid_hp), .o_head_amount(bid_ha),
        .o_full(bid_full)
    );
    lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .VALUE_BITS(VALUE_BITS)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_want_max(1'b0), .i_cmd(ask_cmd),
        .i_cmd_price(r_price), .i_cmd_amount(ask_amt),
        .o_head_valid(ask_hv), .o_head_price(ask_hp), .o_head_amount(ask_ha),
        .o_full(ask_full)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {2'b00, r_total};
    assign m_axis_tuser  = r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_full  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_price <= s_axis_tdata[VALUE_BITS-1:0];
                        r_rem   <= s_axis_tdata[30 +: VALUE_BITS];
                        r_sell  <= s_axis_tuser;
                        r_full  <= 1'b0;
                        r_state <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    if (r_rem != '0 && opp_hv && crosses) begin
                        // consume one level; pop or reduce the head
                        r_total <= mod_sub(r_total, sub_amt);
                        r_rem   <= (opp_amt <= r_rem) ? r_rem - opp_amt : '0;
                    end else begin
                        r_state <= ST_PLACE;
                    end
                end
                ST_PLACE: begin
                    if (r_rem != '0) begin
                        if (own_full) r_full  <= 1'b1;
                        else          r_total <= mod_add(r_total, add_amt);
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_axis_tready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `LOBM_ASSERT_IMP(a_total_range, i_clk, i_rst_n, 1'b1, r_total < BacklogMod,
        "backlog total out of range")
    `LOBM_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, bid_cmd != CMD_NONE, ask_cmd == CMD_NONE,
        "both books commanded at once")
    `LOBM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(r_total), "result changed while stalled")
endmodule
